// ===== rtl/spst_pkg.sv =====
// spst_pkg: shared types, codes and defaults for the sorted point set table
// no dependencies
package spst_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int OUT_BITS       = 32;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_DELETE   = 2'd1;
    localparam logic [1:0] REQ_READ_ASC = 2'd2;
    localparam logic [1:0] REQ_READ_DSC = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_POINT     = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_DELETE    = 3'd5;

    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic is_read;
        logic desc;
    } req_kind_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [OUT_BITS-1:0] x;
        logic [OUT_BITS-1:0] y;
        logic [2:0]          removed;
        logic                last;
    } result_t;

endpackage

// ===== rtl/sorted_point_set_table.sv =====
// sorted_point_set_table: top level, joins the request queue, the cell row
// and the result queue; depends on spst_pkg, spst_front, spst_cells, spst_outq
//
//  channel   handshake            fields
//  request   push / full          req_type, px, py
//  result    empty / pop          status, out_x, out_y, removed_count, last
//
// insert in the cell row: parallel compare, then shift in
// delete: compare, one compaction step per removed point (at most 5), then
// the report; readouts give one item per cycle while the result queue is not
// full, from the cell row's single read mux, or one empty item; reset clears
// queues, count and sequencer at once
// either side may stall: both queues hold two items, the cell row waits
// while the result queue is full
module sorted_point_set_table
    import spst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         status,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [2:0]         removed_count,
    output logic               last
);

    // request handoff between front and cell row
    logic                         req_valid, req_take;
    req_kind_t                    req_kind;
    logic signed [COORD_BITS-1:0] req_x, req_y;

    // result handoff into the result queue
    logic    res_wr, res_full;
    result_t res_data, head;

    spst_front #(.COORD_BITS(COORD_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .px        (px),
        .py        (py),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_kind  (req_kind),
        .req_x     (req_x),
        .req_y     (req_y)
    );

    spst_cells #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_cells
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_kind  (req_kind),
        .req_x     (req_x),
        .req_y     (req_y),
        .res_wr    (res_wr),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    spst_outq u_outq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_data),
        .qfull   (res_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (head)
    );

    // oldest result item on the ports
    assign status        = head.status;
    assign out_x         = head.x;
    assign out_y         = head.y;
    assign removed_count = head.removed;
    assign last          = head.last;

endmodule

// ===== rtl/spst_front.sv =====
// spst_front: input item queue, classifies each item and narrows its coordinates
// depends on spst_pkg
module spst_front
    import spst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   req_type,
    input  logic signed [31:0]           px,
    input  logic signed [31:0]           py,
    output logic                         req_valid,
    input  logic                         req_take,
    output req_kind_t                    req_kind,
    output logic signed [COORD_BITS-1:0] req_x,
    output logic signed [COORD_BITS-1:0] req_y
);

    localparam int WB = (COORD_BITS > 32) ? COORD_BITS : 32;

    req_kind_t                    kind_reg [2];
    logic signed [COORD_BITS-1:0] x_reg [2];
    logic signed [COORD_BITS-1:0] y_reg [2];
    logic                         wptr_reg, rptr_reg;
    logic [1:0]                   cnt_reg;
    logic signed [WB-1:0]         ex, ey;
    req_kind_t                    kind_in;
    logic                         do_push, do_pop;

    assign ex = WB'(px);
    assign ey = WB'(py);

    always_comb
    begin
        kind_in = '0;
        unique case (req_type)
            REQ_INSERT:   kind_in.is_ins = 1'b1;
            REQ_DELETE:   kind_in.is_del = 1'b1;
            REQ_READ_ASC: kind_in.is_read = 1'b1;
            REQ_READ_DSC:
            begin
                kind_in.is_read = 1'b1;
                kind_in.desc    = 1'b1;
            end
            default:      kind_in = '0;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;
    assign req_kind  = kind_reg[rptr_reg];
    assign req_x     = x_reg[rptr_reg];
    assign req_y     = y_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_reg[wptr_reg] <= kind_in;
            x_reg[wptr_reg]    <= ex[COORD_BITS-1:0];
            y_reg[wptr_reg]    <= ey[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= ~wptr_reg;
            if (do_pop)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/spst_outq.sv =====
// spst_outq: two-entry result queue in front of the result ports
// depends on spst_pkg
module spst_outq
    import spst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  result_t wr_data,
    output logic    qfull,
    output logic    empty,
    input  logic    pop,
    output result_t rd_data
);

    result_t    data_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign qfull   = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr && !qfull;
    assign do_rd   = pop && !empty;
    assign rd_data = data_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            data_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= ~wptr_reg;
            if (do_rd)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule

// ===== rtl/spst_cells.sv =====
// spst_cells: row of point cells with compare-and-shift insert, compacting delete
// and readout sequencer; depends on spst_pkg
module spst_cells
    import spst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_take,
    input  req_kind_t                    req_kind,
    input  logic signed [COORD_BITS-1:0] req_x,
    input  logic signed [COORD_BITS-1:0] req_y,
    output logic                         res_wr,
    output result_t                      res_data,
    input  logic                         res_full
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WB = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
    localparam int DW = COORD_BITS + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;
    localparam logic [1:0] S_RD   = 2'd3;

    logic signed [COORD_BITS-1:0] cx_reg [CAPACITY];
    logic signed [COORD_BITS-1:0] cy_reg [CAPACITY];
    logic [CW-1:0]                count_reg;
    logic [1:0]                   state_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic                         desc_reg;
    logic [CAPACITY-1:0]          flag_reg;
    logic                         dup_reg;
    logic [2:0]                   rem_reg;
    logic [CW-1:0]                idx_reg;

    logic [CAPACITY-1:0]          lt, eq, nb, pref;
    logic signed [DW-1:0]         dx [CAPACITY];
    logic signed [DW-1:0]         dy [CAPACITY];
    logic [CW-1:0]                rd_pos;
    logic signed [WB-1:0]         wx, wy;
    logic                         is_full;

    // per-cell compares against the incoming point
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            dx[i] = DW'(cx_reg[i]) - DW'(req_x);
            dy[i] = DW'(cy_reg[i]) - DW'(req_y);
            if (CW'(i) < count_reg)
            begin
                lt[i] = (cy_reg[i] < req_y) || ((cy_reg[i] == req_y) && (cx_reg[i] < req_x));
                eq[i] = (cy_reg[i] == req_y) && (cx_reg[i] == req_x);
                nb[i] = ((dx[i] == '0) && (dy[i] == 1 || dy[i] == -1 || dy[i] == '0))
                     || ((dy[i] == '0) && (dx[i] == 1 || dx[i] == -1));
            end
            else
            begin
                lt[i] = 1'b0;
                eq[i] = 1'b0;
                nb[i] = 1'b0;
            end
        end
    end

    // cells at or above the first flagged one move down
    always_comb
    begin
        pref[0] = flag_reg[0];
        for (int i = 1; i < CAPACITY; i++)
            pref[i] = pref[i-1] | flag_reg[i];
    end

    assign is_full  = (count_reg == CW'(CAPACITY));
    assign req_take = (state_reg == S_IDLE) && req_valid;
    assign rd_pos   = desc_reg ? (count_reg - CW'(1) - idx_reg) : idx_reg;
    assign wx       = WB'(cx_reg[rd_pos[IW-1:0]]);
    assign wy       = WB'(cy_reg[rd_pos[IW-1:0]]);

    always_comb
    begin
        res_wr   = 1'b0;
        res_data = '0;
        res_data.last = 1'b1;
        unique case (state_reg)
            S_IDLE: res_wr = 1'b0;
            S_INS:
            begin
                res_wr = 1'b1;
                if (dup_reg)
                    res_data.status = ST_DUPLICATE;
                else if (is_full)
                    res_data.status = ST_FULL;
                else
                    res_data.status = ST_INSERTED;
            end
            S_DEL:
            begin
                res_wr           = (flag_reg == '0);
                res_data.status  = ST_DELETE;
                res_data.removed = rem_reg;
            end
            S_RD:
            begin
                res_wr = 1'b1;
                if (count_reg == '0)
                    res_data.status = ST_EMPTY;
                else
                begin
                    res_data.status = ST_POINT;
                    res_data.x      = wx[OUT_BITS-1:0];
                    res_data.y      = wy[OUT_BITS-1:0];
                    res_data.last   = (idx_reg == count_reg - CW'(1));
                end
            end
            default: res_wr = 1'b0;
        endcase
    end

    // cell storage
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            x_reg    <= req_x;
            y_reg    <= req_y;
            desc_reg <= req_kind.desc;
            // lt is kept in the flag register for an insert
            flag_reg <= req_kind.is_ins ? lt : nb;
            dup_reg  <= |eq;
            rem_reg  <= '0;
            idx_reg  <= '0;
        end
        else if (state_reg == S_INS && !res_full && !dup_reg && !is_full)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (!flag_reg[i])
                begin
                    if (i == 0)
                    begin
                        cx_reg[i] <= x_reg;
                        cy_reg[i] <= y_reg;
                    end
                    else if (flag_reg[(i > 0) ? i-1 : 0])
                    begin
                        cx_reg[i] <= x_reg;
                        cy_reg[i] <= y_reg;
                    end
                    else
                    begin
                        cx_reg[i] <= cx_reg[(i > 0) ? i-1 : 0];
                        cy_reg[i] <= cy_reg[(i > 0) ? i-1 : 0];
                    end
                end
            end
        end
        else if (state_reg == S_DEL && flag_reg != '0)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (pref[i] && i < CAPACITY - 1)
                begin
                    cx_reg[i]   <= cx_reg[(i < CAPACITY - 1) ? i+1 : i];
                    cy_reg[i]   <= cy_reg[(i < CAPACITY - 1) ? i+1 : i];
                    flag_reg[i] <= flag_reg[(i < CAPACITY - 1) ? i+1 : i];
                end
                else if (pref[i])
                    flag_reg[i] <= 1'b0;
            end
            rem_reg <= rem_reg + 3'd1;
        end
        else if (state_reg == S_RD && !res_full)
            idx_reg <= idx_reg + CW'(1);
    end

    // sequencer and point count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req_kind.is_ins)
                            state_reg <= S_INS;
                        else if (req_kind.is_del)
                            state_reg <= S_DEL;
                        else
                            state_reg <= S_RD;
                    end
                end
                S_INS:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_IDLE;
                        if (!dup_reg && !is_full)
                            count_reg <= count_reg + CW'(1);
                    end
                end
                S_DEL:
                begin
                    if (flag_reg != '0)
                        count_reg <= count_reg - CW'(1);
                    else if (!res_full)
                        state_reg <= S_IDLE;
                end
                S_RD:
                begin
                    if (!res_full && res_data.last)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
